// ===== design/fbpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpt_pkg
// Shared types and constants of the focus/break phase timer.
// ----------------------------------------------------------------------------
package fbpt_pkg;

   localparam int unsigned MS_W    = 24;
   localparam int unsigned DAY_W   = 27;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned SET_W   = 3;
   localparam int unsigned MIN_W   = 8;

   localparam logic [SET_W-1:0] SET_LENGTH = 3'd4;
   localparam logic [SET_W-1:0] SET_MAX    = 3'd7;

   localparam logic [MS_W-1:0] MS_PER_MIN = 24'd60000;

   localparam logic [MIN_W-1:0] FOCUS_MIN_RST = 8'd25;
   localparam logic [MIN_W-1:0] SHORT_MIN_RST = 8'd5;
   localparam logic [MIN_W-1:0] LONG_MIN_RST  = 8'd15;

   localparam logic [MS_W-1:0] FOCUS_MS_RST = 24'(FOCUS_MIN_RST * MS_PER_MIN);
   localparam logic [MS_W-1:0] SHORT_MS_RST = 24'(SHORT_MIN_RST * MS_PER_MIN);
   localparam logic [MS_W-1:0] LONG_MS_RST  = 24'(LONG_MIN_RST * MS_PER_MIN);

   localparam logic [2:0] BEEPS_HIGH = 3'd4;
   localparam logic [2:0] BEEPS_LOW  = 3'd2;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_PAUSE = 3'd2,
      OP_SKIP  = 3'd3,
      OP_STOP  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      PHASE_FOCUS = 2'd0,
      PHASE_SHORT = 2'd1,
      PHASE_LONG  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      TONE_NONE = 2'd0,
      TONE_LOW  = 2'd1,
      TONE_HIGH = 2'd2
   } tone_type;

   typedef enum logic [1:0] {
      REG_FOCUS = 2'd0,
      REG_SHORT = 2'd1,
      REG_LONG  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [1:0]         tone;
      logic [COUNT_W-1:0] done_today;
      logic [SET_W-1:0]   focuses_in_set;
      logic [MS_W-1:0]    remaining_ms;
      logic               on_hold;
      logic               running;
      logic [1:0]         phase;
   } rsp_type;

endpackage

// ===== design/focus_break_phase_timer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// focus_break_phase_timer_unit
// Chained focus / short break / long break countdown with beep queue.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_tready is high. Each accepted item updates
// the timer state in the same cycle and its result leaves through a two-entry
// output queue, which registers it; req_tready drops only while both queue
// entries wait on rsp_tready. Phase lengths are converted from minutes to
// milliseconds when a length register is written, so the item path holds
// only a 24-bit compare and subtract.
module focus_break_phase_timer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] operation, [26:3] elapsed_ms, [53:27] day_stamp, [55:54] zero
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] phase, [2] running, [3] on_hold, [27:4] remaining_ms,
   // [30:28] focuses_in_set, [46:31] done_today, [48:47] tone, [55:49] zero
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration
   logic [7:0]  focus_min_ff, short_min_ff, long_min_ff;
   logic [23:0] focus_ms_ff, short_ms_ff, long_ms_ff;
   logic [23:0] wdata_ms;
   logic        csr_wr;
   fbpt_pkg::reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = fbpt_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wdata_ms   = 24'(csr_pwdata[7:0]) * fbpt_pkg::MS_PER_MIN;

   always_comb begin
      case (csr_idx)
         fbpt_pkg::REG_FOCUS: csr_prdata = {24'd0, focus_min_ff};
         fbpt_pkg::REG_SHORT: csr_prdata = {24'd0, short_min_ff};
         fbpt_pkg::REG_LONG:  csr_prdata = {24'd0, long_min_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focus_min_ff <= fbpt_pkg::FOCUS_MIN_RST;
         short_min_ff <= fbpt_pkg::SHORT_MIN_RST;
         long_min_ff  <= fbpt_pkg::LONG_MIN_RST;
         focus_ms_ff  <= fbpt_pkg::FOCUS_MS_RST;
         short_ms_ff  <= fbpt_pkg::SHORT_MS_RST;
         long_ms_ff   <= fbpt_pkg::LONG_MS_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            fbpt_pkg::REG_FOCUS: begin
               focus_min_ff <= csr_pwdata[7:0];
               focus_ms_ff  <= wdata_ms;
            end
            fbpt_pkg::REG_SHORT: begin
               short_min_ff <= csr_pwdata[7:0];
               short_ms_ff  <= wdata_ms;
            end
            fbpt_pkg::REG_LONG: begin
               long_min_ff <= csr_pwdata[7:0];
               long_ms_ff  <= wdata_ms;
            end
            default: ;
         endcase
      end
   end

   // item fields
   fbpt_pkg::op_type op;
   logic [23:0] elapsed;
   logic [26:0] day;
   logic        accept;

   assign op      = fbpt_pkg::op_type'(req_tdata[2:0]);
   assign elapsed = req_tdata[26:3];
   assign day     = req_tdata[53:27];
   assign accept  = req_tvalid & req_tready;

   // timer state
   fbpt_pkg::phase_type phase_ff, phase_in;
   logic        active_ff, active_in;
   logic        paused_ff, paused_in;
   logic [2:0]  set_ff, set_in;
   logic [23:0] left_ff, left_in;
   logic [2:0]  beeps_ff, beeps_in;
   logic        high_ff, high_in;
   logic [26:0] day_of_ff, day_of_in;
   logic [15:0] today_ff, today_in;
   fbpt_pkg::tone_type tone;

   // phase advance, shared by timeout and skip
   fbpt_pkg::phase_type mv_phase;
   logic [2:0]  mv_set;
   logic [26:0] mv_day;
   logic [15:0] mv_today;
   logic [23:0] mv_ms;
   logic [15:0] today_base;
   logic        finished;

   assign finished   = (op == fbpt_pkg::OP_TICK);
   assign today_base = (day != day_of_ff) ? 16'd0 : today_ff;

   always_comb begin
      mv_set   = set_ff;
      mv_day   = day_of_ff;
      mv_today = today_ff;
      if (phase_ff == fbpt_pkg::PHASE_FOCUS) begin
         if (finished) begin
            mv_set   = (set_ff < fbpt_pkg::SET_MAX) ? set_ff + 3'd1 : set_ff;
            mv_day   = day;
            mv_today = (&today_base) ? today_base : today_base + 16'd1;
         end
         mv_phase = (mv_set >= fbpt_pkg::SET_LENGTH) ? fbpt_pkg::PHASE_LONG
                                                     : fbpt_pkg::PHASE_SHORT;
      end else begin
         if (phase_ff == fbpt_pkg::PHASE_LONG) begin
            mv_set = 3'd0;
         end
         mv_phase = fbpt_pkg::PHASE_FOCUS;
      end
      case (mv_phase)
         fbpt_pkg::PHASE_FOCUS: mv_ms = focus_ms_ff;
         fbpt_pkg::PHASE_SHORT: mv_ms = short_ms_ff;
         default:               mv_ms = long_ms_ff;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      active_in = active_ff;
      paused_in = paused_ff;
      set_in    = set_ff;
      left_in   = left_ff;
      beeps_in  = beeps_ff;
      high_in   = high_ff;
      day_of_in = day_of_ff;
      today_in  = today_ff;
      tone      = fbpt_pkg::TONE_NONE;
      case (op)
         fbpt_pkg::OP_TICK: begin
            if (active_ff && !paused_ff) begin
               if (elapsed < left_ff) begin
                  left_in = left_ff - elapsed;
               end else begin
                  phase_in  = mv_phase;
                  set_in    = mv_set;
                  day_of_in = mv_day;
                  today_in  = mv_today;
                  left_in   = mv_ms;
                  active_in = 1'b1;
                  paused_in = 1'b0;
                  high_in   = (phase_ff == fbpt_pkg::PHASE_FOCUS);
                  beeps_in  = (phase_ff == fbpt_pkg::PHASE_FOCUS) ? fbpt_pkg::BEEPS_HIGH
                                                                  : fbpt_pkg::BEEPS_LOW;
               end
            end
            if (beeps_in != 3'd0) begin
               tone     = high_in ? fbpt_pkg::TONE_HIGH : fbpt_pkg::TONE_LOW;
               beeps_in = beeps_in - 3'd1;
            end
         end
         fbpt_pkg::OP_START: begin
            set_in    = 3'd0;
            phase_in  = fbpt_pkg::PHASE_FOCUS;
            left_in   = focus_ms_ff;
            active_in = 1'b1;
            paused_in = 1'b0;
         end
         fbpt_pkg::OP_PAUSE: begin
            if (active_ff) begin
               paused_in = ~paused_ff;
            end
         end
         fbpt_pkg::OP_SKIP: begin
            if (active_ff) begin
               phase_in  = mv_phase;
               set_in    = mv_set;
               left_in   = mv_ms;
               active_in = 1'b1;
               paused_in = 1'b0;
            end
         end
         fbpt_pkg::OP_STOP: begin
            active_in = 1'b0;
            paused_in = 1'b0;
            left_in   = 24'd0;
            beeps_in  = 3'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= fbpt_pkg::PHASE_FOCUS;
         active_ff <= 1'b0;
         paused_ff <= 1'b0;
         set_ff    <= 3'd0;
         left_ff   <= 24'd0;
         beeps_ff  <= 3'd0;
         high_ff   <= 1'b0;
         day_of_ff <= 27'd0;
         today_ff  <= 16'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         active_ff <= active_in;
         paused_ff <= paused_in;
         set_ff    <= set_in;
         left_ff   <= left_in;
         beeps_ff  <= beeps_in;
         high_ff   <= high_in;
         day_of_ff <= day_of_in;
         today_ff  <= today_in;
      end
   end

   // result
   fbpt_pkg::rsp_type rsp_next, rsp_out;

   always_comb begin
      rsp_next.phase          = phase_in;
      rsp_next.running        = active_in;
      rsp_next.on_hold        = paused_in;
      rsp_next.remaining_ms   = left_in;
      rsp_next.focuses_in_set = set_in;
      rsp_next.done_today     = today_in;
      rsp_next.tone           = tone;
   end

   fbpt_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (rsp_next),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (rsp_out)
   );

   assign rsp_tdata = {7'd0, rsp_out};

   a_hold_needs_run: assert property (@(posedge clock) disable iff (reset)
      paused_ff |-> active_ff)
      else $error("paused without an active cycle");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && op == fbpt_pkg::OP_STOP) |=>
         (!active_ff && !paused_ff && left_ff == 24'd0 && beeps_ff == 3'd0))
      else $error("stop did not clear the timer");

   a_start_focus: assert property (@(posedge clock) disable iff (reset)
      (accept && op == fbpt_pkg::OP_START) |=>
         (active_ff && !paused_ff && phase_ff == fbpt_pkg::PHASE_FOCUS && set_ff == 3'd0))
      else $error("start did not enter a fresh focus");

   a_tone_on_tick: assert property (@(posedge clock) disable iff (reset)
      (accept && op != fbpt_pkg::OP_TICK) |-> (tone == fbpt_pkg::TONE_NONE))
      else $error("tone on a non-tick item");

endmodule

// ===== design/fbpt_rsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpt_rsp_queue
// Two-entry result queue; keeps the input side open while a result waits.
// ----------------------------------------------------------------------------
module fbpt_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  fbpt_pkg::rsp_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output fbpt_pkg::rsp_type pop_data
);

   fbpt_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("result queue pointers inconsistent with count");

   a_pop_keeps: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && !pop_ready) |=> (pop_valid && $stable(rd_ptr_ff)))
      else $error("result queue lost a waiting item");

endmodule
